// ----- rtl/vertex_transform_perspective_divide_unit_defines.svh -----
// assertion macros shared by the rtl
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_UNIT_DEFINES_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define VTPD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vtpd assertion failed");

// next-cycle implication, disabled during reset
`define VTPD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vtpd assertion failed");

`endif

// ----- rtl/vtpd_pkg.sv -----
`default_nettype none
package vtpd_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;
	localparam int PW        = 2 * DW;
	localparam int SW        = PW + 2;
	localparam int QW        = DW + FRAC_BITS;
	localparam int CFG_NUM   = 8;
	localparam int CFG_IW    = 4;
	localparam int CFG_DW    = 64;

	typedef struct packed {
		logic                 hit;
		logic signed [DW-1:0] val;
	} sat_t;

	typedef struct packed {
		logic [2:0][DW-1:0] rem;
		logic [2:0][QW-1:0] dvd;
		logic [3:0][DW-1:0] clip;
		logic [DW-1:0]      dvs;
		logic [2:0]         neg;
		logic               sat;
		logic               wz;
	} div_t;

	// floor to the fixed-point grid, then clip to 32 bits
	function automatic sat_t sat_sum(input logic signed [SW-1:0] s);
		logic signed [SW-1:0] sh;
		sat_t r;
		sh = s >>> FRAC_BITS;
		r.hit = !((&sh[SW-1:DW-1]) || !(|sh[SW-1:DW-1]));
		if (r.hit) begin
			r.val = sh[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			r.val = sh[DW-1:0];
		end
		return r;
	endfunction

	function automatic logic [DW-1:0] abs_fn(input logic [DW-1:0] v);
		return v[DW-1] ? (~v + DW'(1)) : v;
	endfunction

	// one restoring division step on all three lanes
	function automatic div_t div_stage(input div_t d);
		div_t  o;
		logic [DW:0] t;
		o = d;
		for (int i = 0; i < 3; i++) begin
			t = {d.rem[i], d.dvd[i][QW-1]} - {1'b0, d.dvs};
			if (!t[DW]) begin
				o.rem[i] = t[DW-1:0];
				o.dvd[i] = {d.dvd[i][QW-2:0], 1'b1};
			end else begin
				o.rem[i] = {d.rem[i][DW-2:0], d.dvd[i][QW-1]};
				o.dvd[i] = {d.dvd[i][QW-2:0], 1'b0};
			end
		end
		return o;
	endfunction

	// signed quotient from magnitude and sign, clipped to 32 bits
	function automatic sat_t ndc_fn(input logic [QW-1:0] q, input logic neg);
		sat_t r;
		if (neg) begin
			r.hit = (|q[QW-1:DW]) || (q[DW-1] && (|q[DW-2:0]));
			r.val = r.hit ? {1'b1, {(DW-1){1'b0}}} : (~q[DW-1:0] + DW'(1));
		end else begin
			r.hit = |q[QW-1:DW-1];
			r.val = r.hit ? {1'b0, {(DW-1){1'b1}}} : q[DW-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/vtpd_ifs.sv -----
`default_nettype none
interface vtpd_in_if;
	logic                          valid;
	logic                          ready;
	logic signed [vtpd_pkg::DW-1:0] in_x;
	logic signed [vtpd_pkg::DW-1:0] in_y;
	logic signed [vtpd_pkg::DW-1:0] in_z;
	logic signed [vtpd_pkg::DW-1:0] in_w;
	modport source (output valid, in_x, in_y, in_z, in_w, input ready);
	modport sink (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

interface vtpd_out_if;
	logic                          valid;
	logic                          ready;
	logic signed [vtpd_pkg::DW-1:0] clip_x;
	logic signed [vtpd_pkg::DW-1:0] clip_y;
	logic signed [vtpd_pkg::DW-1:0] clip_z;
	logic signed [vtpd_pkg::DW-1:0] clip_w;
	logic signed [vtpd_pkg::DW-1:0] ndc_x;
	logic signed [vtpd_pkg::DW-1:0] ndc_y;
	logic signed [vtpd_pkg::DW-1:0] ndc_z;
	logic                          w_zero;
	logic                          saturated;
	modport source (output valid, clip_x, clip_y, clip_z, clip_w, ndc_x, ndc_y, ndc_z,
		w_zero, saturated, input ready);
	modport sink (input valid, clip_x, clip_y, clip_z, clip_w, ndc_x, ndc_y, ndc_z,
		w_zero, saturated, output ready);
endinterface

interface vtpd_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [vtpd_pkg::CFG_IW-1:0]      index;
	logic [vtpd_pkg::CFG_DW-1:0]      data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/vertex_transform_perspective_divide_unit.sv -----
// vertex transform with perspective divide
// vin carries one point (x, y, z, w) in signed Q16.16 per beat; vout returns
// clip x/y/z/w, ndc x/y/z, w_zero and saturated for every point, in order.
// cfg writes the eight 64-bit matrix registers, two coefficients each; write
// only while no point is in flight. cfg is always ready, indexes 8 and up are
// dropped.
// a point passes through 51 register stages on its way to vout: one multiply
// stage (16 parallel 32x32 multipliers), one sum and clip stage, 48 stages of a
// one-bit-per-stage restoring divider (three lanes sharing the divisor) and the
// output register.
// throughput: one point per cycle while vout does not stall.
// reset clears the matrix to zero and drops all valid bits.
// when vout stalls, the whole pipe holds and vin.ready drops; no beat is lost
// or repeated. a point may enter in the same cycle the output beat leaves.
`default_nettype none
`include "vertex_transform_perspective_divide_unit_defines.svh"
module vertex_transform_perspective_divide_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	vtpd_in_if.sink     vin,
	vtpd_out_if.source  vout,
	vtpd_cfg_if.sink    cfg
);

	logic [vtpd_pkg::CFG_NUM-1:0][vtpd_pkg::CFG_DW-1:0] cfg_q;
	logic en;

	logic signed [vtpd_pkg::DW-1:0] pt [4];
	logic signed [vtpd_pkg::PW-1:0] prod_s1 [4][4];
	logic                           vld_s1;

	logic signed [vtpd_pkg::SW-1:0] sum [4];
	vtpd_pkg::sat_t                 ss [4];
	logic [3:0][vtpd_pkg::DW-1:0]   clip_s2;
	logic                           sat_s2;
	logic                           vld_s2;

	vtpd_pkg::div_t div_in [vtpd_pkg::QW];
	vtpd_pkg::div_t div_s [vtpd_pkg::QW];
	logic [vtpd_pkg::QW-1:0] dv_vld_s;
	vtpd_pkg::div_t dl;
	vtpd_pkg::sat_t nq [3];

	logic                           out_vld_q;
	logic [3:0][vtpd_pkg::DW-1:0]   clip_q;
	logic [2:0][vtpd_pkg::DW-1:0]   ndc_q;
	logic                           wz_q;
	logic                           sat_q;

	assign en = !out_vld_q || vout.ready;
	assign vin.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid && (cfg.index < vtpd_pkg::CFG_IW'(vtpd_pkg::CFG_NUM))) begin
			cfg_q[cfg.index[2:0]] <= cfg.data;
		end
	end

	assign pt[0] = vin.in_x;
	assign pt[1] = vin.in_y;
	assign pt[2] = vin.in_z;
	assign pt[3] = vin.in_w;

	// stage 1: products
	for (genvar r = 0; r < 4; r++) begin : g_row
		for (genvar c = 0; c < 4; c++) begin : g_col
			always_ff @(posedge clk) begin
				if (en) begin
					prod_s1[r][c] <= $signed(cfg_q[2*r + c/2][vtpd_pkg::DW*(c%2) +: vtpd_pkg::DW])
						* pt[c];
				end
			end
		end
		assign sum[r] = vtpd_pkg::SW'(prod_s1[r][0]) + vtpd_pkg::SW'(prod_s1[r][1])
			+ vtpd_pkg::SW'(prod_s1[r][2]) + vtpd_pkg::SW'(prod_s1[r][3]);
		assign ss[r] = vtpd_pkg::sat_sum(sum[r]);
	end

	// stage 2: row sums, clipped
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				clip_s2[r] <= ss[r].val;
			end
			sat_s2 <= ss[0].hit || ss[1].hit || ss[2].hit || ss[3].hit;
		end
	end

	// divider setup from stage 2
	always_comb begin
		div_in[0].rem  = '0;
		div_in[0].clip = clip_s2;
		div_in[0].dvs  = vtpd_pkg::abs_fn(clip_s2[3]);
		div_in[0].sat  = sat_s2;
		div_in[0].wz   = (clip_s2[3] == '0);
		for (int i = 0; i < 3; i++) begin
			div_in[0].dvd[i] = {vtpd_pkg::abs_fn(clip_s2[i]), {vtpd_pkg::FRAC_BITS{1'b0}}};
			div_in[0].neg[i] = clip_s2[i][vtpd_pkg::DW-1] ^ clip_s2[3][vtpd_pkg::DW-1];
		end
	end

	for (genvar k = 0; k < vtpd_pkg::QW; k++) begin : g_div
		if (k > 0) begin : g_link
			assign div_in[k] = div_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k] <= vtpd_pkg::div_stage(div_in[k]);
			end
		end
	end

	assign dl = div_s[vtpd_pkg::QW-1];
	for (genvar i = 0; i < 3; i++) begin : g_ndc
		assign nq[i] = vtpd_pkg::ndc_fn(dl.dvd[i], dl.neg[i]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clip_q <= dl.clip;
			wz_q   <= dl.wz;
			for (int i = 0; i < 3; i++) begin
				ndc_q[i] <= dl.wz ? '0 : nq[i].val;
			end
			sat_q <= dl.sat || (!dl.wz && (nq[0].hit || nq[1].hit || nq[2].hit));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			dv_vld_s  <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= vin.valid;
			vld_s2    <= vld_s1;
			dv_vld_s  <= {dv_vld_s[vtpd_pkg::QW-2:0], vld_s2};
			out_vld_q <= dv_vld_s[vtpd_pkg::QW-1];
		end
	end

	assign vout.valid     = out_vld_q;
	assign vout.clip_x    = clip_q[0];
	assign vout.clip_y    = clip_q[1];
	assign vout.clip_z    = clip_q[2];
	assign vout.clip_w    = clip_q[3];
	assign vout.ndc_x     = ndc_q[0];
	assign vout.ndc_y     = ndc_q[1];
	assign vout.ndc_z     = ndc_q[2];
	assign vout.w_zero    = wz_q;
	assign vout.saturated = sat_q;

	`VTPD_ASSERT_IMP(a_wz_match, out_vld_q, wz_q == (clip_q[3] == '0))
	`VTPD_ASSERT_IMP(a_wz_ndc, out_vld_q && wz_q, ndc_q == '0)
	`VTPD_ASSERT_NXT(a_stall_hold, out_vld_q && !vout.ready, out_vld_q && $stable(ndc_q))

endmodule
`default_nettype wire

// ----- verif/vtpd_tb_ifs.sv -----
`timescale 1ns / 1ps
package vtpd_tb_pkg;

	typedef struct packed {
		logic signed [vtpd_pkg::DW-1:0] cx, cy, cz, cw, nx, ny, nz;
		logic                           wz, sat;
	} vertex_out_t;
endpackage

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

	localparam int DW        = vtpd_pkg::DW;
	localparam int FRAC_BITS = vtpd_pkg::FRAC_BITS;
	localparam int CFG_NUM   = vtpd_pkg::CFG_NUM;
	localparam int CFG_IW    = vtpd_pkg::CFG_IW;
	localparam int CFG_DW    = vtpd_pkg::CFG_DW;

	localparam int LATENCY = 50;

	localparam logic [CFG_IW-1:0] REG_R0_C01 = 4'd0;
	localparam logic [CFG_IW-1:0] REG_R0_C23 = 4'd1;
	localparam logic [CFG_IW-1:0] REG_R1_C01 = 4'd2;
	localparam logic [CFG_IW-1:0] REG_R1_C23 = 4'd3;
	localparam logic [CFG_IW-1:0] REG_R2_C01 = 4'd4;
	localparam logic [CFG_IW-1:0] REG_R2_C23 = 4'd5;
	localparam logic [CFG_IW-1:0] REG_R3_C01 = 4'd6;
	localparam logic [CFG_IW-1:0] REG_R3_C23 = 4'd7;
	localparam logic [CFG_IW-1:0] REG_NONE   = 4'd12;

	localparam logic [DW-1:0] ONE  = 32'h0001_0000;
	localparam logic [DW-1:0] MAXV = 32'h7fff_ffff;
	localparam logic [DW-1:0] MINV = 32'h8000_0000;

	logic clk;
	logic arst_n;

	vtpd_in_if  vin();
	vtpd_out_if vout();
	vtpd_cfg_if cfg();

	vertex_transform_perspective_divide_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vin    (vin.sink),
		.vout   (vout.source),
		.cfg    (cfg.sink)
	);

	logic [CFG_DW-1:0]       matrix_regs [CFG_NUM];
	vtpd_tb_pkg::vertex_out_t pending_vertices[$];
	int                      mismatches;
	int                      sink_idle_pct;
	int                      src_idle_pct;
	int                      sink_gap;
	bit                      hold_sink;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAIL vertex_transform_perspective_divide_unit");
		$finish;
	end

	function automatic logic signed [DW-1:0] coef_of(int r, int c);
		logic [CFG_DW-1:0] w;
		w = matrix_regs[2 * r + c / 2];
		return (c % 2) ? w[63:32] : w[31:0];
	endfunction

	function automatic logic signed [DW-1:0] clip32(input logic signed [127:0] v,
		inout logic hit);
		if (v > $signed(128'sh7fff_ffff)) begin
			hit = 1'b1;
			return MAXV;
		end
		if (v < -$signed(128'sh8000_0000)) begin
			hit = 1'b1;
			return MINV;
		end
		return v[DW-1:0];
	endfunction

	function automatic vtpd_tb_pkg::vertex_out_t transform_vertex(logic signed [DW-1:0] pt [4]);
		vtpd_tb_pkg::vertex_out_t o;
		logic signed [127:0]  acc;
		logic signed [127:0]  q;
		logic signed [DW-1:0] clip [4];
		logic signed [DW-1:0] ndc [3];
		logic                 hit;
		hit = 1'b0;
		for (int r = 0; r < 4; r++) begin
			acc = 0;
			for (int c = 0; c < 4; c++)
				acc += 128'(coef_of(r, c)) * 128'(pt[c]);
			clip[r] = clip32(acc >>> FRAC_BITS, hit);
		end
		o.wz = (clip[3] == 0);
		for (int r = 0; r < 3; r++) begin
			if (o.wz) begin
				ndc[r] = '0;
			end else begin
				q = (128'(clip[r]) <<< FRAC_BITS) / 128'(clip[3]);
				ndc[r] = clip32(q, hit);
			end
		end
		o.cx = clip[0]; o.cy = clip[1]; o.cz = clip[2]; o.cw = clip[3];
		o.nx = ndc[0]; o.ny = ndc[1]; o.nz = ndc[2];
		o.sat = hit;
		return o;
	endfunction

	// leaves valid high; load_matrix drops it after the last beat
	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		if (idx < CFG_NUM) matrix_regs[idx] = val;
	endtask

	task automatic send_vertex(logic signed [DW-1:0] x, y, z, w);
		logic signed [DW-1:0] pt [4];
		int gap;
		if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			vin.valid <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
		end
		vin.valid <= 1'b1;
		vin.in_x <= x; vin.in_y <= y; vin.in_z <= z; vin.in_w <= w;
		do @(posedge clk); while (!vin.ready);
		pt = '{x, y, z, w};
		pending_vertices.push_back(transform_vertex(pt));
	endtask

	task automatic drain();
		vin.valid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic load_matrix(logic [CFG_DW-1:0] m [CFG_NUM]);
		write_reg(REG_R0_C01, m[0]);
		write_reg(REG_R0_C23, m[1]);
		write_reg(REG_R1_C01, m[2]);
		write_reg(REG_R1_C23, m[3]);
		write_reg(REG_R2_C01, m[4]);
		write_reg(REG_R2_C23, m[5]);
		write_reg(REG_R3_C01, m[6]);
		write_reg(REG_R3_C23, m[7]);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [DW-1:0] rand_field();
		case ($urandom_range(5))
			0: return MAXV;
			1: return MINV;
			2: return $urandom_range(0, 8) << 16;
			3: return -($urandom_range(0, 8) << 16);
			default: return $urandom;
		endcase
	endfunction

	// output side: random idle bursts on ready, compare each beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout.ready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (vout.valid && vout.ready) begin
				vtpd_tb_pkg::vertex_out_t e, a;
				a = '{vout.clip_x, vout.clip_y, vout.clip_z, vout.clip_w, vout.ndc_x,
					vout.ndc_y, vout.ndc_z, vout.w_zero, vout.saturated};
				if (pending_vertices.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected output beat act %p", a);
				end else begin
					e = pending_vertices.pop_front();
					if (e !== a) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp %p act %p", e, a);
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				vout.ready <= 1'b0;
			end else if (sink_idle_pct > 0 && $urandom_range(99) < sink_idle_pct) begin
				sink_gap = $urandom_range(1, 4) - 1;
				vout.ready <= 1'b0;
			end else begin
				vout.ready <= !hold_sink;
			end
		end
	end

	task automatic test_identity();
		logic [CFG_DW-1:0] m [CFG_NUM];
		m = '{{32'd0, ONE}, 64'd0, {ONE, 32'd0}, 64'd0,
			64'd0, {32'd0, ONE}, 64'd0, {ONE, 32'd0}};
		write_reg(REG_NONE, '1);
		load_matrix(m);
		send_vertex(ONE, 2 * ONE, 3 * ONE, 2 * ONE);
		send_vertex(MAXV, MINV, 32'd0, ONE);
		send_vertex(ONE, ONE, ONE, 32'd0);
		send_vertex(MINV, MINV, MINV, MINV);
		send_vertex(MAXV, MAXV, MAXV, MAXV);
		send_vertex(MAXV, 32'd5, -32'sd7, 32'd1);
		send_vertex(-32'sd3, 32'd3, ONE, -32'sd1);
		drain();
	endtask

	task automatic test_extreme_matrix();
		logic [CFG_DW-1:0] m [CFG_NUM];
		m = '{{MAXV, MAXV}, {MAXV, MAXV}, {MINV, MINV}, {MINV, MINV},
			{MINV, MAXV}, {MAXV, MINV}, {MINV, MINV}, {MINV, MINV}};
		load_matrix(m);
		send_vertex(MAXV, MAXV, MAXV, MAXV);
		send_vertex(MINV, MINV, MINV, MINV);
		send_vertex(MINV, MAXV, MINV, MAXV);
		send_vertex(-32'sd1, -32'sd1, -32'sd1, -32'sd1);
		send_vertex(32'd0, 32'd0, 32'd0, 32'd0);
		// floor of a tiny negative w sum
		m = '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, {32'd0, 32'd1}, 64'd0};
		drain();
		load_matrix(m);
		send_vertex(-32'sd1, 32'd0, 32'd0, 32'd0);
		send_vertex(32'd1, 32'd0, 32'd0, 32'd0);
		drain();
	endtask

	task automatic test_random_phase(int n, int src_pct, int sink_pct);
		logic [CFG_DW-1:0] m [CFG_NUM];
		for (int i = 0; i < CFG_NUM; i++)
			m[i] = {rand_field(), rand_field()};
		load_matrix(m);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		for (int i = 0; i < n; i++)
			send_vertex(rand_field(), rand_field(), rand_field(), rand_field());
		drain();
	endtask

	task automatic test_backpressure();
		int hold;
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		hold_sink = 1'b1;
		fork
			begin
				hold = 0;
				while (hold < 200) begin
					@(posedge clk);
					hold++;
				end
				hold_sink = 1'b0;
			end
			for (int i = 0; i < 80; i++)
				send_vertex($urandom, $urandom, $urandom, $urandom);
		join
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		vin.valid = 1'b0;
		vin.in_x = '0; vin.in_y = '0; vin.in_z = '0; vin.in_w = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data  = '0;
		hold_sink = 1'b0;
		mismatches = 0;
		sink_idle_pct = 0;
		src_idle_pct = 0;
		for (int i = 0; i < CFG_NUM; i++) matrix_regs[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_vertex(ONE, ONE, ONE, ONE);
		drain();
		test_identity();
		test_extreme_matrix();
		test_random_phase(80, 30, 30);
		test_random_phase(80, 10, 50);
		test_backpressure();
		test_random_phase(80, 50, 10);
		test_random_phase(80, 0, 0);
		if (mismatches == 0 && pending_vertices.size() == 0) begin
			$display("PASS vertex_transform_perspective_divide_unit");
		end else begin
			$display("FAIL vertex_transform_perspective_divide_unit");
		end
		$finish;
	end
endmodule
